// ===== design/assert_macros.svh =====
// assertion macros used by top_three_share_of_total_unit
// uses the clk and rst_n names of the module that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tss_pkg.sv =====
// shared types and constants for the top three share of total block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int VOL_W      = 32;
    localparam int TOTAL_W    = 44;
    localparam int TOP3_W     = 33;
    localparam int FRAC_SHIFT = 16;
    localparam int DIVIDEND_W = TOP3_W + FRAC_SHIFT;
    localparam int SHARE_W    = 32;
    localparam int STEP_W     = $clog2(DIVIDEND_W);
    localparam int KEPT_W     = 2;

    localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(3);

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
    localparam logic [SHARE_W-1:0] SHARE_MAX = {1'b0, {(SHARE_W-1){1'b1}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_RUN,
        S_EMIT
    } tss_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== design/tss_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [tss_pkg::DIVIDEND_W-1:0]  dividend,
    input  wire logic [tss_pkg::TOTAL_W-1:0]     divisor,
    output tss_pkg::div_status_t                 status,
    output logic [tss_pkg::DIVIDEND_W-1:0]       quotient
);
    import tss_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TOTAL_W-1:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [TOTAL_W-1:0]    divisor_reg, divisor_next;
    logic [TOTAL_W:0]      trial;
    logic [TOTAL_W:0]      diff;
    logic                  fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        divisor_reg <= divisor_next;
    end

    // dividend bits shift out at the top, quotient bits shift in at the bottom
    always_comb
    begin
        trial        = {rem_reg, num_reg[DIVIDEND_W-1]};
        diff         = trial - {1'b0, divisor_reg};
        fits         = trial >= {1'b0, divisor_reg};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        num_next     = num_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = STEP_W'(DIVIDEND_W - 1);
            rem_next     = '0;
            num_next     = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
            num_next  = {num_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = num_reg;

endmodule

`default_nettype wire

// ===== design/top_three_share_of_total_unit.sv =====
// top three share of total: per-group top three tracking and final division
// depends on tss_pkg, tss_div and assert_macros.svh
//
// input channel: volume, is_finite, last with in_valid / in_stall. a word is
// taken when in_valid is high and in_stall is low. a word with is_finite low
// is skipped; last closes the group.
// output channel: share, share_valid with out_valid / out_stall. one word per
// group, taken when out_valid is high and out_stall is low.
// throughput: a word that is not last is taken every cycle. after a last word
// in_stall stays high while the sequencer runs the 49-step restoring divider,
// one quotient bit per cycle, and until the output register takes the result.
// a result waiting on out_stall does not block the next group's words; only
// the end of the next group waits until the output register is free.
// reset clears the running statistics, the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module top_three_share_of_total_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [tss_pkg::VOL_W-1:0] volume,
    input  wire logic                          is_finite,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [tss_pkg::SHARE_W-1:0] share,
    output logic                               share_valid
);
    import tss_pkg::*;

    tss_state_t state_reg, state_next;

    logic signed [VOL_W-1:0]   largest_reg, largest_next;
    logic signed [VOL_W-1:0]   second_reg, second_next;
    logic signed [VOL_W-1:0]   third_reg, third_next;
    logic [KEPT_W-1:0]         kept_count_reg, kept_count_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic                      any_kept_reg, any_kept_next;
    logic                      calc_valid_reg, calc_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic [SHARE_W-1:0]        share_reg, share_next;
    logic                      share_valid_reg, share_valid_next;

    logic                      in_accept;
    logic                      out_free;
    logic signed [TOTAL_W:0]   total_sum;
    logic                      gt_l, gt_s, gt_t;
    logic signed [TOP3_W:0]    top3_sum;
    logic [TOP3_W-1:0]         top3_clamp;
    logic                      div_start;
    logic [DIVIDEND_W-1:0]     dividend;
    logic [DIVIDEND_W-1:0]     quotient;
    div_status_t               div_status;

    tss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (total_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            largest_reg     <= '0;
            second_reg      <= '0;
            third_reg       <= '0;
            kept_count_reg  <= '0;
            total_reg       <= '0;
            any_kept_reg    <= 1'b0;
            calc_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            largest_reg     <= largest_next;
            second_reg      <= second_next;
            third_reg       <= third_next;
            kept_count_reg  <= kept_count_next;
            total_reg       <= total_next;
            any_kept_reg    <= any_kept_next;
            calc_valid_reg  <= calc_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        share_reg       <= share_next;
        share_valid_reg <= share_valid_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign total_sum = {total_reg[TOTAL_W-1], total_reg} + (TOTAL_W+1)'(volume);
    assign gt_l      = volume > largest_reg;
    assign gt_s      = volume > second_reg;
    assign gt_t      = volume > third_reg;

    // only the first kept_count places hold real samples
    assign top3_sum =
        ((kept_count_reg != '0) ? (TOP3_W+1)'(largest_reg) : '0) +
        ((kept_count_reg >= KEPT_W'(2)) ? (TOP3_W+1)'(second_reg) : '0) +
        ((kept_count_reg == KEPT_MAX) ? (TOP3_W+1)'(third_reg) : '0);
    assign top3_clamp = top3_sum[TOP3_W] ? '0 : top3_sum[TOP3_W-1:0];
    assign dividend   = {top3_clamp, {FRAC_SHIFT{1'b0}}};

    always_comb
    begin
        state_next       = state_reg;
        largest_next     = largest_reg;
        second_next      = second_reg;
        third_next       = third_reg;
        kept_count_next  = kept_count_reg;
        total_next       = total_reg;
        any_kept_next    = any_kept_reg;
        calc_valid_next  = calc_valid_reg;
        out_valid_next   = out_valid_reg;
        share_next       = share_reg;
        share_valid_next = share_valid_reg;
        div_start        = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (is_finite)
                    begin
                        // saturating total
                        if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1])
                        begin
                            total_next = total_sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
                        end
                        else
                        begin
                            total_next = total_sum[TOTAL_W-1:0];
                        end
                        any_kept_next = 1'b1;
                        if (kept_count_reg != KEPT_MAX)
                        begin
                            kept_count_next = kept_count_reg + KEPT_W'(1);
                        end
                        unique case (kept_count_reg)
                            KEPT_W'(0):
                            begin
                                largest_next = volume;
                            end
                            KEPT_W'(1):
                            begin
                                if (gt_l)
                                begin
                                    second_next  = largest_reg;
                                    largest_next = volume;
                                end
                                else
                                begin
                                    second_next = volume;
                                end
                            end
                            default:
                            begin
                                if (gt_l)
                                begin
                                    third_next   = second_reg;
                                    second_next  = largest_reg;
                                    largest_next = volume;
                                end
                                else if (gt_s)
                                begin
                                    third_next  = second_reg;
                                    second_next = volume;
                                end
                                else if (gt_t || kept_count_reg != KEPT_MAX)
                                begin
                                    third_next = volume;
                                end
                            end
                        endcase
                    end
                    if (last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                calc_valid_next = any_kept_reg && !total_reg[TOTAL_W-1] && (total_reg != '0);
                div_start       = 1'b1;
                state_next      = S_RUN;
            end
            S_RUN:
            begin
                if (div_status.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    share_valid_next = calc_valid_reg;
                    if (!calc_valid_reg)
                    begin
                        share_next = '0;
                    end
                    else if (quotient[DIVIDEND_W-1:SHARE_W-1] != '0)
                    begin
                        share_next = SHARE_MAX;
                    end
                    else
                    begin
                        share_next = quotient[SHARE_W-1:0];
                    end
                    largest_next    = '0;
                    second_next     = '0;
                    third_next      = '0;
                    kept_count_next = '0;
                    total_next      = '0;
                    any_kept_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign share       = share_reg;
    assign share_valid = share_valid_reg;

    `ASSERT_IMPL(a_kept_match, 1'b1, any_kept_reg == (kept_count_reg != '0), "kept flag and count disagree")
    `ASSERT_IMPL(a_idle_div, state_reg == S_IDLE, !div_status.busy, "divider busy while idle")
    `ASSERT_NEXT(a_last_start, in_accept && last, state_reg == S_START, "last word did not start division")
    `ASSERT_IMPL(a_invalid_zero, out_valid_reg && !share_valid_reg, share_reg == '0, "invalid result not zero")

endmodule

`default_nettype wire
